>>> src/iasp_pkg.sv
// Shared types, constants and arithmetic helpers for the idle-air PID stepper.
// Used by the PID pipeline, the valve stage and the top level; no dependencies.

package iasp_pkg;

    // Configuration register indexes, in port order
    localparam logic [2:0] CFG_VALVE_TYPE    = 3'd0;
    localparam logic [2:0] CFG_OVERRIDE_RPM  = 3'd1;
    localparam logic [2:0] CFG_PROFILE_RPM   = 3'd2;
    localparam logic [2:0] CFG_GAIN_P        = 3'd3;
    localparam logic [2:0] CFG_GAIN_I        = 3'd4;
    localparam logic [2:0] CFG_GAIN_D        = 3'd5;
    localparam logic [2:0] CFG_MAX_STEPS     = 3'd6;

    // Register values after reset
    localparam logic [1:0]  RST_VALVE_TYPE   = 2'd1;
    localparam logic [13:0] RST_OVERRIDE_RPM = 14'd1200;
    localparam logic [13:0] RST_PROFILE_RPM  = 14'd850;
    localparam logic [7:0]  RST_MAX_STEPS    = 8'd200;

    // Valve type that disables closed-loop updates
    localparam logic [1:0]  VALVE_NONE       = 2'd0;

    // Gains used when the register holds zero (hundredths)
    localparam logic [9:0]  DEF_KP           = 10'd50;
    localparam logic [9:0]  DEF_KI           = 10'd10;
    localparam logic [9:0]  DEF_KD           = 10'd5;

    // Integral clamp
    localparam logic signed [20:0] INT_HI    = 21'sd5000;
    localparam logic signed [20:0] INT_LO    = -21'sd5000;

    // ceil(2^32 / 100): exact floor division by 100 for operands below 2^30
    localparam logic [25:0] RECIP_100        = 26'd42949673;

    // Step saturation: no move ever exceeds the 8-bit position range
    localparam logic [18:0] STEP_SAT         = 19'd255;

    // What an item does as it travels down the pipeline
    typedef enum logic [1:0] {
        KIND_UPD = 2'd0,
        KIND_PRE = 2'd1,
        KIND_NOP = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  valve_type;
        logic [13:0] override_target_rpm;
        logic [13:0] profile_target_rpm;
        logic [9:0]  gain_p;
        logic [9:0]  gain_i;
        logic [9:0]  gain_d;
        logic [7:0]  max_valve_steps;
    } cfg_t;

    // Per-item tag carried alongside the arithmetic
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         tbl;
        logic signed [14:0] err;
    } tag_t;

    // PID result handed to the valve stage
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         tbl;
        logic signed [14:0] err;
        logic signed [13:0] int_val;
        logic               step_neg;
        logic [7:0]         step_mag;
    } pid_res_t;

    // Floor of n / 100 by reciprocal multiply
    function automatic logic [18:0] udiv100(input logic [24:0] n);
        logic [50:0] prod;
        prod = 51'(n) * 51'(RECIP_100);
        return prod[50:32];
    endfunction

    // Signed division by 100, truncating toward zero
    function automatic logic signed [20:0] sdiv100(input logic signed [26:0] v);
        logic [26:0] mag;
        logic [20:0] q;
        mag = v[26] ? 27'(-v) : 27'(v);
        q   = 21'(udiv100(mag[24:0]));
        return v[26] ? -$signed(q) : $signed(q);
    endfunction

    // Preposition step count from coolant in tenths; thresholds on the
    // whole-degree value truncated toward zero
    function automatic logic [7:0] prepos_steps(input logic signed [11:0] c);
        logic [7:0] s;
        if (c < -12'sd209)
            s = 8'd80;
        else if (c < -12'sd9)
            s = 8'd70;
        else if (c < 12'sd200)
            s = 8'd60;
        else if (c < 12'sd400)
            s = 8'd45;
        else if (c < 12'sd600)
            s = 8'd30;
        else if (c < 12'sd800)
            s = 8'd18;
        else
            s = 8'd10;
        return s;
    endfunction

endpackage

>>> src/iasp_pid.sv
// PID pipeline of the idle-air stepper: error, gain products, scaling,
// clamped integral and step count. Depends on iasp_pkg.

module iasp_pid (
    input  logic                      clk,
    input  logic                      rst_n,
    input  iasp_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_func,
    input  logic [13:0]               in_rpm,
    input  logic signed [11:0]        in_coolant,
    output logic                      res_valid,
    input  logic                      res_free,
    output iasp_pkg::pid_res_t        res
);

    localparam int NSTG = 7;

    // Pipeline occupancy and flow
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   free;
    logic [NSTG-1:0] src;
    logic [NSTG-1:0] load;

    // Stage 1: input register
    logic               s1_func_reg;
    logic [13:0]        s1_rpm_reg;
    logic signed [11:0] s1_cool_reg;

    // Stage 2: error and table value
    iasp_pkg::tag_t     s2_reg;
    // Stage 3: gain products
    iasp_pkg::tag_t     s3_reg;
    logic signed [26:0] s3_pp_reg, s3_pi_reg, s3_pd_reg;
    // Stage 4: scaled terms
    iasp_pkg::tag_t     s4_reg;
    logic signed [20:0] s4_qp_reg, s4_qi_reg, s4_qd_reg;
    // Stage 5: integral and partial sum
    iasp_pkg::tag_t     s5_reg;
    logic signed [13:0] s5_int_reg;
    logic signed [21:0] s5_psum_reg;
    // Stage 6: controller output as sign and magnitude
    iasp_pkg::tag_t     s6_reg;
    logic signed [13:0] s6_int_reg;
    logic               s6_neg_reg;
    logic [20:0]        s6_mag_reg;
    // Stage 7: step count
    iasp_pkg::tag_t     s7_reg;
    logic signed [13:0] s7_int_reg;
    logic               s7_neg_reg;
    logic [7:0]         s7_mag_reg;

    // Controller state
    logic signed [14:0] last_err_reg;
    logic signed [13:0] int_reg;

    // Combinational terms
    logic [13:0]        target;
    iasp_pkg::kind_t    kind_c;
    logic signed [14:0] err_raw;
    iasp_pkg::tag_t     s2_next;
    logic [9:0]         kp, ki, kd;
    logic signed [15:0] diff;
    logic signed [26:0] pp_c, pi_c, pd_c;
    logic signed [20:0] int_sum;
    logic signed [20:0] int_clamp;
    logic signed [13:0] int_next;
    logic signed [13:0] int_val_c;
    logic signed [21:0] psum_c;
    logic signed [21:0] outv;
    logic [21:0]        out_abs;
    logic [18:0]        step_q;

    // Ready chain: a stage is free when empty or when it drains this cycle
    always_comb
    begin
        free[NSTG] = res_free;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            free[k] = !vld_reg[k] || free[k+1];
        end
    end

    assign src      = {vld_reg[NSTG-2:0], in_valid};
    assign load     = src & free[NSTG-1:0];
    assign in_ready = free[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= (free[NSTG-1:0] & src) | (~free[NSTG-1:0] & vld_reg);
    end

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_func_reg <= in_func;
            s1_rpm_reg  <= in_rpm;
            s1_cool_reg <= in_coolant;
        end
    end

    // Classify the item and form the speed error
    assign target  = (cfg.override_target_rpm != 14'd0) ? cfg.override_target_rpm
                                                        : cfg.profile_target_rpm;
    assign err_raw = $signed({1'b0, target}) - $signed({1'b0, s1_rpm_reg});

    always_comb
    begin
        if (s1_func_reg)
            kind_c = iasp_pkg::KIND_PRE;
        else if (cfg.valve_type == iasp_pkg::VALVE_NONE)
            kind_c = iasp_pkg::KIND_NOP;
        else
            kind_c = iasp_pkg::KIND_UPD;
        s2_next.kind = kind_c;
        s2_next.tbl  = iasp_pkg::prepos_steps(s1_cool_reg);
        s2_next.err  = (kind_c == iasp_pkg::KIND_UPD) ? err_raw : 15'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
            s2_reg <= s2_next;
    end

    // Gain products; the derivative uses the previous update's error
    assign kp   = (cfg.gain_p != 10'd0) ? cfg.gain_p : iasp_pkg::DEF_KP;
    assign ki   = (cfg.gain_i != 10'd0) ? cfg.gain_i : iasp_pkg::DEF_KI;
    assign kd   = (cfg.gain_d != 10'd0) ? cfg.gain_d : iasp_pkg::DEF_KD;
    assign diff = $signed({s2_reg.err[14], s2_reg.err})
                - $signed({last_err_reg[14], last_err_reg});
    assign pp_c = $signed({{12{s2_reg.err[14]}}, s2_reg.err}) * $signed({17'd0, kp});
    assign pi_c = $signed({{12{s2_reg.err[14]}}, s2_reg.err}) * $signed({17'd0, ki});
    assign pd_c = $signed({{11{diff[15]}}, diff}) * $signed({17'd0, kd});

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_reg    <= s2_reg;
            s3_pp_reg <= pp_c;
            s3_pi_reg <= pi_c;
            s3_pd_reg <= pd_c;
        end
    end

    // Hold the error of the update that has just left the error stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_err_reg <= '0;
        else if (load[2] && s2_reg.kind == iasp_pkg::KIND_UPD)
            last_err_reg <= s2_reg.err;
    end

    // Scale each product by one hundredth
    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_reg    <= s3_reg;
            s4_qp_reg <= iasp_pkg::sdiv100(s3_pp_reg);
            s4_qi_reg <= iasp_pkg::sdiv100(s3_pi_reg);
            s4_qd_reg <= iasp_pkg::sdiv100(s3_pd_reg);
        end
    end

    // Accumulate and clamp the integral
    assign int_sum   = $signed({{7{int_reg[13]}}, int_reg}) + s4_qi_reg;
    assign int_clamp = (int_sum > iasp_pkg::INT_HI) ? iasp_pkg::INT_HI :
                       (int_sum < iasp_pkg::INT_LO) ? iasp_pkg::INT_LO : int_sum;
    assign int_next  = int_clamp[13:0];
    assign int_val_c = (s4_reg.kind == iasp_pkg::KIND_UPD) ? int_next : int_reg;
    assign psum_c    = $signed({s4_qp_reg[20], s4_qp_reg})
                     + $signed({s4_qd_reg[20], s4_qd_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            int_reg <= '0;
        else if (load[4] && s4_reg.kind == iasp_pkg::KIND_UPD)
            int_reg <= int_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_reg      <= s4_reg;
            s5_int_reg  <= int_val_c;
            s5_psum_reg <= psum_c;
        end
    end

    // Sum the three terms and split into sign and magnitude
    assign outv    = s5_psum_reg + $signed({{8{s5_int_reg[13]}}, s5_int_reg});
    assign out_abs = outv[21] ? 22'(-outv) : 22'(outv);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_reg     <= s5_reg;
            s6_int_reg <= s5_int_reg;
            s6_neg_reg <= outv[21];
            s6_mag_reg <= out_abs[20:0];
        end
    end

    // Step count, saturated to the position range
    assign step_q = iasp_pkg::udiv100({4'd0, s6_mag_reg});

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_reg     <= s6_reg;
            s7_int_reg <= s6_int_reg;
            s7_neg_reg <= s6_neg_reg;
            s7_mag_reg <= (step_q > iasp_pkg::STEP_SAT) ? 8'hFF : step_q[7:0];
        end
    end

    assign res_valid    = vld_reg[NSTG-1];
    assign res.kind     = s7_reg.kind;
    assign res.tbl      = s7_reg.tbl;
    assign res.err      = s7_reg.err;
    assign res.int_val  = s7_int_reg;
    assign res.step_neg = s7_neg_reg;
    assign res.step_mag = s7_mag_reg;

endmodule

>>> src/iasp_valve.sv
// Valve stage of the idle-air stepper: position tracking, move limiting and
// the result register. Depends on iasp_pkg.

module iasp_valve (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           max_valve_steps,
    input  logic                 in_valid,
    output logic                 in_free,
    input  iasp_pkg::pid_res_t   res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 home_first,
    output logic                 step_dir,
    output logic [7:0]           step_count,
    output logic [7:0]           valve_position,
    output logic signed [14:0]   rpm_error,
    output logic signed [13:0]   integral_value
);

    logic               out_valid_reg;
    logic [7:0]         pos_reg;
    logic               home_reg;
    logic               dir_reg;
    logic [7:0]         cnt_reg;
    logic [7:0]         opos_reg;
    logic signed [14:0] err_reg;
    logic signed [13:0] int_reg;

    logic               load;
    logic [7:0]         room;
    logic               home_c;
    logic               dir_c;
    logic [7:0]         cnt_c;
    logic [7:0]         pos_next;

    assign in_free = !out_valid_reg || out_ready;
    assign load    = in_valid && in_free;
    assign room    = max_valve_steps - pos_reg;

    // Limit update moves so the valve stays between closed and the maximum; a preposition goes to its table value
    always_comb
    begin
        home_c   = 1'b0;
        dir_c    = 1'b0;
        cnt_c    = 8'd0;
        pos_next = pos_reg;
        case (res.kind)
            iasp_pkg::KIND_PRE:
            begin
                home_c   = 1'b1;
                cnt_c    = res.tbl;
                pos_next = res.tbl;
            end
            iasp_pkg::KIND_UPD:
            begin
                if (!res.step_neg && res.step_mag != 8'd0 && pos_reg < max_valve_steps)
                begin
                    cnt_c    = (res.step_mag < room) ? res.step_mag : room;
                    pos_next = pos_reg + cnt_c;
                end
                else if (res.step_neg && res.step_mag != 8'd0 && pos_reg != 8'd0)
                begin
                    dir_c    = 1'b1;
                    cnt_c    = (res.step_mag < pos_reg) ? res.step_mag : pos_reg;
                    pos_next = pos_reg - cnt_c;
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    // Advance position on each transfer into the result register; output valid follows the input whenever it is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (load)
                pos_reg <= pos_next;
            if (in_free)
                out_valid_reg <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            home_reg <= home_c;
            dir_reg  <= dir_c;
            cnt_reg  <= cnt_c;
            opos_reg <= pos_next;
            err_reg  <= res.err;
            int_reg  <= res.int_val;
        end
    end

    assign out_valid      = out_valid_reg;
    assign home_first     = home_reg;
    assign step_dir       = dir_reg;
    assign step_count     = cnt_reg;
    assign valve_position = opos_reg;
    assign rpm_error      = err_reg;
    assign integral_value = int_reg;

endmodule

>>> src/idle_air_pid_stepper.sv
// Top level of the idle-air PID stepper: configuration registers, stream
// ports, PID pipeline and valve stage. Depends on iasp_pkg, iasp_pid, iasp_valve.
//
//  channel   direction  transfer when                  payload
//  s_axis    in         s_axis_tvalid & s_axis_tready  update or preposition item
//  m_axis    out        m_axis_tvalid & m_axis_tready  one move result per item
//  cfg       in         cfg_wr_en                      register write, no read-back
//
// One item is taken every cycle while s_axis_tready is high; at the input transfer
// the input register loads, six stages follow (error, gain products, scaling,
// integral, output sum, step count), then the result register offers the result.
// Reset restores the registers to their defaults and clears position,
// integral and last error at once; items are taken from the first cycle.
// A stall on m_axis fills empty stages first, then holds s_axis_tready low.
// A preposition result sets home_first, on which the homing run is issued
// downstream.

module idle_air_pid_stepper (
    input  logic        clk,
    input  logic        rst_n,
    // engine_rpm [13:0], coolant_tenths [25:14], zero [31:26]
    input  logic [31:0] s_axis_tdata,
    // func [0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // step_dir [0], step_count [8:1], valve_position [16:9],
    // rpm_error [31:17], integral_value [45:32], zero [47:46]
    output logic [47:0] m_axis_tdata,
    // home_first [0]
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    iasp_pkg::cfg_t     cfg_reg;
    iasp_pkg::pid_res_t pid_res;
    logic               pid_valid;
    logic               valve_free;
    logic               step_dir;
    logic [7:0]         step_count;
    logic [7:0]         valve_position;
    logic signed [14:0] rpm_error;
    logic signed [13:0] integral_value;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valve_type          <= iasp_pkg::RST_VALVE_TYPE;
            cfg_reg.override_target_rpm <= iasp_pkg::RST_OVERRIDE_RPM;
            cfg_reg.profile_target_rpm  <= iasp_pkg::RST_PROFILE_RPM;
            cfg_reg.gain_p              <= '0;
            cfg_reg.gain_i              <= '0;
            cfg_reg.gain_d              <= '0;
            cfg_reg.max_valve_steps     <= iasp_pkg::RST_MAX_STEPS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                iasp_pkg::CFG_VALVE_TYPE:   cfg_reg.valve_type          <= cfg_data[1:0];
                iasp_pkg::CFG_OVERRIDE_RPM: cfg_reg.override_target_rpm <= cfg_data;
                iasp_pkg::CFG_PROFILE_RPM:  cfg_reg.profile_target_rpm  <= cfg_data;
                iasp_pkg::CFG_GAIN_P:       cfg_reg.gain_p              <= cfg_data[9:0];
                iasp_pkg::CFG_GAIN_I:       cfg_reg.gain_i              <= cfg_data[9:0];
                iasp_pkg::CFG_GAIN_D:       cfg_reg.gain_d              <= cfg_data[9:0];
                iasp_pkg::CFG_MAX_STEPS:    cfg_reg.max_valve_steps     <= cfg_data[7:0];
                default:                    cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    iasp_pid u_pid (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (s_axis_tuser),
        .in_rpm     (s_axis_tdata[13:0]),
        .in_coolant ($signed(s_axis_tdata[25:14])),
        .res_valid  (pid_valid),
        .res_free   (valve_free),
        .res        (pid_res)
    );

    iasp_valve u_valve (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_valve_steps (cfg_reg.max_valve_steps),
        .in_valid        (pid_valid),
        .in_free         (valve_free),
        .res             (pid_res),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .home_first      (m_axis_tuser),
        .step_dir        (step_dir),
        .step_count      (step_count),
        .valve_position  (valve_position),
        .rpm_error       (rpm_error),
        .integral_value  (integral_value)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {2'b00, integral_value, rpm_error, valve_position,
                           step_count, step_dir};

endmodule

>>> src/iasp_checker.sv
// Port assertions for the idle-air PID stepper, bound to the top level.
// Depends on the top level's port list only.

module iasp_port_assert (
    input logic        clk,
    input logic        rst_n,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A preposition opens to its table value with no error reported
    a_prepos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[0] == 1'b0 && m_axis_tdata[8:1] == m_axis_tdata[16:9]
            && m_axis_tdata[31:17] == 15'd0)
        else $error("preposition result inconsistent");

    // Integral stays inside its clamp
    a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[45:32]) <= 14'sd5000
            && $signed(m_axis_tdata[45:32]) >= -14'sd5000)
        else $error("integral outside clamp");

endmodule

bind idle_air_pid_stepper iasp_port_assert u_iasp_checker (.*);
